// ===== src/aafp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aafp_pkg
// Shared types and constants for the angle-arc block: field widths, the
// CORDIC working word and the arctangent table in 2^32-per-turn units.
// ----------------------------------------------------------------------------
package aafp_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int COORD_W = 32;   // Q16.16 input coordinates
	localparam int DIFF_W  = 33;   // exact arm vector components
	localparam int VEC_W   = 36;   // CORDIC x/y with headroom for gain and negation
	localparam int ZACC_W  = 32;   // angle accumulator, full turn = 2^32
	localparam int OUT_W   = 16;   // result angle field width
	localparam int TAB_N   = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [VEC_W-1:0]   vec_t;
	typedef logic        [ZACC_W-1:0]  zacc_t;
	typedef logic        [OUT_W-1:0]   angle16_t;

	// one CORDIC stage word
	typedef struct packed {
		vec_t  x;
		vec_t  y;
		zacc_t z;
		logic  zero;
	} cordic_t;

	// atan(2^-i) in units of 2^-32 turn
	localparam zacc_t ATAN_TAB [TAB_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage
`default_nettype wire

// ===== src/aafp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aafp_if
// Valid/ready channels: point sets in, arc descriptions out.
// ----------------------------------------------------------------------------
interface aafp_pts_if;
	logic             valid;
	logic             ready;
	aafp_pkg::coord_t first_x;
	aafp_pkg::coord_t first_y;
	aafp_pkg::coord_t vertex_x;
	aafp_pkg::coord_t vertex_y;
	aafp_pkg::coord_t second_x;
	aafp_pkg::coord_t second_y;
	logic             has_second;

	modport source (output valid, first_x, first_y, vertex_x, vertex_y,
		second_x, second_y, has_second, input ready);
	modport sink (input valid, first_x, first_y, vertex_x, vertex_y,
		second_x, second_y, has_second, output ready);
endinterface

interface aafp_arc_if;
	logic               valid;
	logic               ready;
	aafp_pkg::angle16_t start_angle;
	aafp_pkg::angle16_t sweep_angle;
	logic               right_mark;

	modport source (output valid, start_angle, sweep_angle, right_mark, input ready);
	modport sink (input valid, start_angle, sweep_angle, right_mark, output ready);
endinterface
`default_nettype wire

// ===== src/aafp_cordic_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aafp_cordic_step
// One registered CORDIC vectoring iteration: rotate toward y = 0 by
// atan(2^-STEP) and accumulate the angle.
// ----------------------------------------------------------------------------
module aafp_cordic_step #(
	parameter int STEP = 0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire aafp_pkg::cordic_t d,
	output aafp_pkg::cordic_t      q_s1
);

	aafp_pkg::vec_t    xs;
	aafp_pkg::vec_t    ys;
	aafp_pkg::cordic_t nxt;

	always_comb begin
		xs = d.x >>> STEP;
		ys = d.y >>> STEP;
		nxt.zero = d.zero;
		if (!d.y[aafp_pkg::VEC_W-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + aafp_pkg::ATAN_TAB[STEP];
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - aafp_pkg::ATAN_TAB[STEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== src/aafp_atan2.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aafp_atan2
// Pipelined atan2: half-plane fold, CORDIC_STEPS vectoring stages, then
// rounding of the 32-bit angle to ANGLE_BITS. Stage enables come from the
// owner so side data can travel in lockstep.
// ----------------------------------------------------------------------------
module aafp_atan2 #(
	parameter int ANGLE_BITS   = aafp_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = aafp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                    clk,
	input  wire logic [CORDIC_STEPS+1:0] en,
	input  wire aafp_pkg::diff_t         vx,
	input  wire aafp_pkg::diff_t         vy,
	output logic [ANGLE_BITS-1:0]        angle_s3
);

	localparam int SH = aafp_pkg::ZACC_W - ANGLE_BITS;
	localparam logic [aafp_pkg::ZACC_W:0] RC_W = (aafp_pkg::ZACC_W+1)'(1) << SH;
	localparam aafp_pkg::zacc_t RC = RC_W[aafp_pkg::ZACC_W:1];

	aafp_pkg::cordic_t pre_s1;
	aafp_pkg::cordic_t cdc_s2 [CORDIC_STEPS];
	aafp_pkg::vec_t    xe;
	aafp_pkg::vec_t    ye;
	aafp_pkg::zacc_t   zr;

	assign xe = aafp_pkg::VEC_W'(vx);
	assign ye = aafp_pkg::VEC_W'(vy);

	// left half-plane: negate and start from half a turn
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pre_s1.zero <= (vx == '0) && (vy == '0);
			if (vx[aafp_pkg::DIFF_W-1]) begin
				pre_s1.x <= -xe;
				pre_s1.y <= -ye;
				pre_s1.z <= {1'b1, {(aafp_pkg::ZACC_W-1){1'b0}}};
			end else begin
				pre_s1.x <= xe;
				pre_s1.y <= ye;
				pre_s1.z <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		aafp_cordic_step #(
			.STEP(i)
		) u_step (
			.clk (clk),
			.en  (en[i+1]),
			.d   ((i == 0) ? pre_s1 : cdc_s2[(i == 0) ? 0 : i-1]),
			.q_s1(cdc_s2[i])
		);
	end

	// round half up, wrap modulo one turn
	assign zr = cdc_s2[CORDIC_STEPS-1].z + RC;

	always_ff @(posedge clk) begin
		if (en[CORDIC_STEPS+1]) begin
			angle_s3 <= cdc_s2[CORDIC_STEPS-1].zero ? '0 : zr[aafp_pkg::ZACC_W-1:SH];
		end
	end

endmodule
`default_nettype wire

// ===== src/angle_arc_from_three_points.sv =====
// Throughput: one point set per cycle unless a stall at the output backs up to
// the input; the two arm directions run in twin CORDIC pipelines, one register
// stage per iteration, with per-stage stall.
// A stalled output holds its beat while empty stages upstream keep filling.
// Reset clears all stage valid bits and half_mode; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_arc_from_three_points
// Start angle and counter-clockwise sweep of the angle at a vertex, with
// optional folding to the smaller arc.
// ----------------------------------------------------------------------------
module angle_arc_from_three_points #(
	parameter int ANGLE_BITS   = aafp_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = aafp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	aafp_pts_if.sink    pts,
	aafp_arc_if.source  arc,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata
);

	localparam int D  = CORDIC_STEPS + 2;   // atan2 unit depth
	localparam int NS = CORDIC_STEPS + 4;   // total stages
	localparam logic [ANGLE_BITS-1:0] HALF    = {1'b1, {(ANGLE_BITS-1){1'b0}}};
	localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

	logic                  half_mode_q;
	logic [NS:0]           en;
	logic [NS-1:0]         vld_q;

	aafp_pkg::diff_t       lx_s1, ly_s1, rx_s1, ry_s1;
	logic                  two_s1, lzero_s1;
	logic                  two_s2   [D];
	logic                  lzero_s2 [D];
	logic [ANGLE_BITS-1:0] ang_l, ang_r;

	logic [ANGLE_BITS-1:0] sweep0, start_n, sweep_n;
	logic                  mark_n;
	logic [ANGLE_BITS-1:0] start_s3, sweep_s3;
	logic                  mark_s3;
	logic [ANGLE_BITS+aafp_pkg::OUT_W-1:0] start_ext, sweep_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_mode_q <= 1'b0;
		end else if (cfg_we) begin
			half_mode_q <= cfg_wdata;
		end
	end

	// a stage loads when empty or when its contents move on
	assign en[NS] = arc.ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end
	assign pts.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= pts.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// arm vectors
	always_ff @(posedge clk) begin
		if (en[0]) begin
			lx_s1    <= {pts.first_x[31], pts.first_x} - {pts.vertex_x[31], pts.vertex_x};
			ly_s1    <= {pts.first_y[31], pts.first_y} - {pts.vertex_y[31], pts.vertex_y};
			rx_s1    <= {pts.second_x[31], pts.second_x} - {pts.vertex_x[31], pts.vertex_x};
			ry_s1    <= {pts.second_y[31], pts.second_y} - {pts.vertex_y[31], pts.vertex_y};
			two_s1   <= pts.has_second;
			lzero_s1 <= (pts.first_x == pts.vertex_x) && (pts.first_y == pts.vertex_y);
		end
	end

	aafp_atan2 #(
		.ANGLE_BITS  (ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_atan_l (
		.clk     (clk),
		.en      (en[D:1]),
		.vx      (lx_s1),
		.vy      (ly_s1),
		.angle_s3(ang_l)
	);

	aafp_atan2 #(
		.ANGLE_BITS  (ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_atan_r (
		.clk     (clk),
		.en      (en[D:1]),
		.vx      (rx_s1),
		.vy      (ry_s1),
		.angle_s3(ang_r)
	);

	// flags ride alongside the atan2 stages
	always_ff @(posedge clk) begin
		if (en[1]) begin
			two_s2[0]   <= two_s1;
			lzero_s2[0] <= lzero_s1;
		end
		for (int k = 1; k < D; k++) begin
			if (en[k+1]) begin
				two_s2[k]   <= two_s2[k-1];
				lzero_s2[k] <= lzero_s2[k-1];
			end
		end
	end

	always_comb begin
		if (two_s2[D-1]) begin
			sweep0 = ang_r - ang_l;
		end else begin
			sweep0 = lzero_s2[D-1] ? '0 : QUARTER;
		end
		start_n = ang_l;
		sweep_n = sweep0;
		mark_n  = two_s2[D-1];
		if (half_mode_q) begin
			mark_n = 1'b1;
			if (sweep0 > HALF) begin
				start_n = ang_l + sweep0;
				sweep_n = -sweep0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			start_s3 <= start_n;
			sweep_s3 <= sweep_n;
			mark_s3  <= mark_n;
		end
	end

	assign start_ext = {{aafp_pkg::OUT_W{1'b0}}, start_s3};
	assign sweep_ext = {{aafp_pkg::OUT_W{1'b0}}, sweep_s3};

	assign arc.valid       = vld_q[NS-1];
	assign arc.start_angle = start_ext[aafp_pkg::OUT_W-1:0];
	assign arc.sweep_angle = sweep_ext[aafp_pkg::OUT_W-1:0];
	assign arc.right_mark  = mark_s3;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for angle_arc_from_three_points. Point sets go in through a
// valid/ready driver with random gaps; a second clocked process takes the
// arc beats with random stalls and compares them field by field against an
// in-bench CORDIC atan2 predictor. half_mode is switched between phases.
// ----------------------------------------------------------------------------
module tb;
	typedef aafp_pkg::coord_t   coord_t;
	typedef aafp_pkg::angle16_t angle16_t;

	localparam int          PIPE_LAT  = 20;
	localparam int unsigned RUN_LIMIT = 300000;
	localparam int          PHASE_N   = 305;
	localparam angle16_t    HALF_TURN    = 16'h8000;
	localparam angle16_t    QUARTER_TURN = 16'h4000;
	localparam coord_t      C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t      C_MIN = 32'sh8000_0000;

	// atan(2^-i), full turn = 2^32
	localparam logic [31:0] ATAN_STEP [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t vertex_x;
		coord_t vertex_y;
		coord_t second_x;
		coord_t second_y;
		logic   has_second;
	} point_set_t;

	typedef struct packed {
		angle16_t start_angle;
		angle16_t sweep_angle;
		logic     right_mark;
	} arc_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	aafp_pts_if pts_ch ();
	aafp_arc_if arc_ch ();

	angle_arc_from_three_points i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts       (pts_ch),
		.arc       (arc_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	point_set_t  point_queue [$];
	arc_t        arc_expect [$];
	bit          fold_q;
	int unsigned error_count;
	int unsigned cycle_cnt;
	int unsigned src_wait;
	int unsigned snk_wait;
	int unsigned pts_taken;
	int unsigned arcs_taken;
	bit          src_idle;
	bit          snk_idle;

	// CORDIC vectoring, same step count and rounding as the block
	function automatic angle16_t arm_direction(longint ax, longint ay);
		longint      nx;
		longint      ny;
		logic [31:0] acc;
		logic [32:0] rounded;
		if (ax == 0 && ay == 0)
			return '0;
		acc = '0;
		if (ax < 0) begin
			ax = -ax;
			ay = -ay;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < 16; i++) begin
			if (ay >= 0) begin
				nx = ax + (ay >>> i);
				ny = ay - (ax >>> i);
				acc = acc + ATAN_STEP[i];
			end else begin
				nx = ax - (ay >>> i);
				ny = ay + (ax >>> i);
				acc = acc - ATAN_STEP[i];
			end
			ax = nx;
			ay = ny;
		end
		rounded = {1'b0, acc} + 33'h0_0000_8000;
		return rounded[31:16];
	endfunction

	function automatic arc_t predict_arc(point_set_t p, bit fold);
		longint ux;
		longint uy;
		longint vx;
		longint vy;
		arc_t   r;
		ux = longint'(p.first_x) - longint'(p.vertex_x);
		uy = longint'(p.first_y) - longint'(p.vertex_y);
		r.start_angle = arm_direction(ux, uy);
		if (p.has_second) begin
			vx = longint'(p.second_x) - longint'(p.vertex_x);
			vy = longint'(p.second_y) - longint'(p.vertex_y);
			r.sweep_angle = arm_direction(vx, vy) - r.start_angle;
			r.right_mark = 1'b1;
		end else begin
			r.sweep_angle = (ux == 0 && uy == 0) ? 16'h0000 : QUARTER_TURN;
			r.right_mark = 1'b0;
		end
		if (fold) begin
			if (r.sweep_angle > HALF_TURN) begin
				r.start_angle = r.start_angle + r.sweep_angle;
				r.sweep_angle = 16'h0000 - r.sweep_angle;
			end
			r.right_mark = 1'b1;
		end
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return coord_t'($urandom);
			2: return coord_t'($urandom_range(0, 4095) - 2048);
			3: begin
				case ($urandom_range(0, 4))
					0: return C_MAX;
					1: return C_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			// random magnitude at a random scale
			default: return coord_t'($urandom >> $urandom_range(0, 31));
		endcase
	endfunction

	function automatic coord_t near(coord_t c);
		return c + coord_t'($urandom_range(0, 255) - 128);
	endfunction

	function automatic point_set_t rand_point_set();
		point_set_t p;
		p.vertex_x = rand_coord();
		p.vertex_y = rand_coord();
		case ($urandom_range(0, 15))
			0: begin
				p.first_x = p.vertex_x;
				p.first_y = p.vertex_y;
			end
			1, 2, 3, 4, 5, 6: begin
				p.first_x = near(p.vertex_x);
				p.first_y = near(p.vertex_y);
			end
			default: begin
				p.first_x = rand_coord();
				p.first_y = rand_coord();
			end
		endcase
		case ($urandom_range(0, 15))
			0: begin
				p.second_x = p.vertex_x;
				p.second_y = p.vertex_y;
			end
			// mirror of the first arm through the vertex: half-turn sweep
			1: begin
				p.second_x = 2 * p.vertex_x - p.first_x;
				p.second_y = 2 * p.vertex_y - p.first_y;
			end
			2, 3, 4, 5, 6: begin
				p.second_x = near(p.vertex_x);
				p.second_y = near(p.vertex_y);
			end
			default: begin
				p.second_x = rand_coord();
				p.second_y = rand_coord();
			end
		endcase
		p.has_second = ($urandom_range(0, 3) != 0);
		return p;
	endfunction

	task automatic queue_points(coord_t fx, coord_t fy, coord_t vx, coord_t vy,
		coord_t sx, coord_t sy, logic two);
		point_set_t p;
		p = '{fx, fy, vx, vy, sx, sy, two};
		point_queue.insert(point_queue.size(), p);
	endtask

	task automatic queue_directed();
		queue_points(0, 0, 0, 0, 0, 0, 1'b0);
		queue_points(0, 0, 0, 0, 0, 0, 1'b1);
		queue_points(1, 0, 0, 0, 9, 9, 1'b0);
		queue_points(-1, 0, 0, 0, 0, -1, 1'b1);
		queue_points(15, 13, 10, 10, 5, 7, 1'b1);
		queue_points(0, 1, 0, 0, 1, 0, 1'b1);
		queue_points(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, 1'b1);
		queue_points(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 1'b1);
		queue_points(C_MIN, 0, 0, 0, 0, C_MIN, 1'b1);
		queue_points(-1, -1, 0, 0, -1, 1, 1'b1);
		queue_points(0, -3, 0, 0, 0, 0, 1'b0);
		queue_points(7, 0, 0, 0, 7, -1, 1'b1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (point_queue.size() != 0 || pts_ch.valid || arc_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_half_mode(bit v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fold_q = v;
		@(negedge clk);
	endtask

	// point set driver
	always @(posedge clk or negedge arst_n) begin : drive_points
		point_set_t nxt;
		arc_t       pred;
		if (!arst_n) begin
			pts_ch.valid <= 1'b0;
			src_wait <= 0;
			pts_taken <= 0;
			src_idle <= 1'b1;
		end else begin
			if (pts_ch.valid && pts_ch.ready) begin
				pred = predict_arc('{pts_ch.first_x, pts_ch.first_y,
					pts_ch.vertex_x, pts_ch.vertex_y, pts_ch.second_x, pts_ch.second_y,
					pts_ch.has_second}, fold_q);
				arc_expect.insert(arc_expect.size(), pred);
				pts_taken <= pts_taken + 1;
				if (pts_taken % 64 == 63)
					src_idle <= ($urandom_range(0, 2) != 0);
			end
			if (!pts_ch.valid || pts_ch.ready) begin
				if (src_wait != 0) begin
					pts_ch.valid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (point_queue.size() != 0) begin
					nxt = point_queue.pop_front();
					pts_ch.first_x <= nxt.first_x;
					pts_ch.first_y <= nxt.first_y;
					pts_ch.vertex_x <= nxt.vertex_x;
					pts_ch.vertex_y <= nxt.vertex_y;
					pts_ch.second_x <= nxt.second_x;
					pts_ch.second_y <= nxt.second_y;
					pts_ch.has_second <= nxt.has_second;
					pts_ch.valid <= 1'b1;
					src_wait <= src_idle ? $urandom_range(0, 19) : 0;
				end else begin
					pts_ch.valid <= 1'b0;
				end
			end
		end
	end

	// arc receiver and checker
	always @(posedge clk or negedge arst_n) begin : take_arcs
		int unsigned w;
		arc_t        exp_arc;
		if (!arst_n) begin
			arc_ch.ready <= 1'b0;
			snk_wait <= 0;
			arcs_taken <= 0;
			snk_idle <= 1'b1;
		end else if (arc_ch.valid && arc_ch.ready) begin
			if (arc_expect.size() == 0) begin
				$error("arc beat with no point set pending: start_angle %0d sweep_angle %0d",
					arc_ch.start_angle, arc_ch.sweep_angle);
				error_count++;
			end else begin
				exp_arc = arc_expect.pop_front();
				if (arc_ch.start_angle !== exp_arc.start_angle) begin
					$error("start_angle: expected %0d, got %0d", exp_arc.start_angle,
						arc_ch.start_angle);
					error_count++;
				end
				if (arc_ch.sweep_angle !== exp_arc.sweep_angle) begin
					$error("sweep_angle: expected %0d, got %0d", exp_arc.sweep_angle,
						arc_ch.sweep_angle);
					error_count++;
				end
				if (arc_ch.right_mark !== exp_arc.right_mark) begin
					$error("right_mark: expected %0d, got %0d", exp_arc.right_mark,
						arc_ch.right_mark);
					error_count++;
				end
			end
			arcs_taken <= arcs_taken + 1;
			if (arcs_taken % 64 == 31)
				snk_idle <= ($urandom_range(0, 2) != 0);
			w = snk_idle ? $urandom_range(0, 19) : 0;
			// long hold-off so the pipeline fills and backs up into the input
			if (arcs_taken == 400 || arcs_taken == 1300)
				w = 400;
			snk_wait <= w;
			arc_ch.ready <= (w == 0);
		end else if (snk_wait != 0) begin
			snk_wait <= snk_wait - 1;
			arc_ch.ready <= (snk_wait == 1);
		end else begin
			arc_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	initial begin : watchdog
		while (cycle_cnt < RUN_LIMIT)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		cycle_cnt = 0;
		error_count = 0;
		fold_q = 1'b0;
		pts_ch.valid = 1'b0;
		pts_ch.first_x = '0;
		pts_ch.first_y = '0;
		pts_ch.vertex_x = '0;
		pts_ch.vertex_y = '0;
		pts_ch.second_x = '0;
		pts_ch.second_y = '0;
		pts_ch.has_second = 1'b0;
		arc_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_half_mode(1'b0);
		queue_directed();
		wait_drained();
		write_half_mode(1'b1);
		queue_directed();

		foreach (ATAN_STEP[k]) begin
			if (k >= 6)
				break;
			wait_drained();
			write_half_mode(k inside {1, 3, 4});
			for (int n = 0; n < PHASE_N; n++)
				point_queue.insert(point_queue.size(), rand_point_set());
		end

		wait_drained();
		repeat (2 * PIPE_LAT) @(posedge clk);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/aafp_pkg.sv
src/aafp_if.sv
src/aafp_cordic_step.sv
src/aafp_atan2.sv
src/angle_arc_from_three_points.sv
bench/tb.sv
